[rtl/vtb_pkg.sv]
// ============================================================================
// Vertex transform bounds: shared package
// Register indexes, sequencer codes and fixed field widths.
// ============================================================================
package vtb_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int SCALE_WIDTH     = 32;
    localparam int COORD_FRAC      = 16;
    localparam int DIST_WIDTH      = 63;
    localparam int RADIUS_WIDTH    = 32;

    localparam logic [63:0] DIST_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [SCALE_WIDTH-1:0] SCALE_ONE = 32'sh0001_0000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_COSINE   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_SINE     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE_DIAG_A = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE_DIAG_B = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE_HEIGHT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIAG,
        ST_COMB,
        ST_UPDATE,
        ST_SQRT,
        ST_DONE
    } state_t;

    // One code per pass through the shared multiplier, in issue order.
    typedef enum logic [3:0] {
        STEP_SIN_Z,
        STEP_COS_X,
        STEP_COS_Z,
        STEP_SIN_X,
        STEP_A_D,
        STEP_B_S,
        STEP_H_Y,
        STEP_SQ_X,
        STEP_SQ_Y,
        STEP_SQ_Z
    } step_t;

endpackage

[rtl/vertex_transform_bounds_core.sv]
// ============================================================================
// Vertex transform bounds core
// Rotates, diagonally scales and height-scales one vertex per word, tracks
// the running bounding box and bounding sphere of the mesh.
// ============================================================================
//
//  Channel   Direction  Handshake           Payload
//  --------  ---------  ------------------  ---------------------------------
//  s_        in         s_tvalid/s_tready   s_tdata pos_x,y,z; s_tlast final
//  m_        out        m_tvalid/m_tready   m_tdata results; m_tlast is_last
//  cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  The result word is loaded into the output register once the vertex has
//  passed the steps below, and on a final vertex after the square root as
//  well; the next word is taken after that load at the earliest. The steps
//  are ten passes through the single shared multiplier (multiply, then
//  shift, clamp and accumulate), four further steps (difference and sum,
//  final combine, bounds update, output load) and the one-bit-pair-per-
//  cycle square root loop. Reset is synchronous and active low; it restores
//  the register defaults and marks the next vertex as the start of a mesh.
//  A stalled output holds its word; the core waits in its last state until
//  the output register is free and is not ready for input while busy.
//
module vertex_transform_bounds_core #(
    parameter int COORD_WIDTH    = 32,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    // pos_x, pos_y, pos_z from the lowest bit up, zero-padded to bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic s_tlast,

    output logic m_tvalid,
    input  logic m_tready,
    // out_x, out_y, out_z, box_min_x/y/z, box_max_x/y/z, radius_squared,
    // radius from the lowest bit up, zero-padded to bytes
    output logic [((9*COORD_WIDTH+vtb_pkg::DIST_WIDTH+vtb_pkg::RADIUS_WIDTH+7)/8)*8-1:0]
                 m_tdata,
    output logic m_tlast,

    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [vtb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [vtb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import vtb_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int TW    = TRIG_FRAC_BITS + 1;
    localparam int OPW   = (CW > SCALE_WIDTH) ? CW : SCALE_WIDTH;
    localparam int PW    = 2 * OPW;
    localparam int SW    = CW + 2;
    localparam int MAGW  = 64;
    localparam int M_BITS = 9 * CW + DIST_WIDTH + RADIUS_WIDTH;
    localparam int M_DW   = ((M_BITS + 7) / 8) * 8;
    localparam int RSQ_LSB = 9 * CW;
    localparam int RAD_LSB = 9 * CW + DIST_WIDTH;

    localparam logic signed [CW-1:0] CW_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CW_MIN = {1'b1, {(CW-1){1'b0}}};

    // Clamp a widened sum to the signed coordinate range.
    function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SW'(CW_MAX)) begin
            r = CW_MAX;
        end else if (v < SW'(CW_MIN)) begin
            r = CW_MIN;
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic [OPW-1:0] mag_of(input logic signed [OPW:0] v);
        logic signed [OPW:0] n;
        n = -v;
        return v[OPW] ? n[OPW-1:0] : v[OPW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The port is ready whenever the core is out
    // of reset; writes are expected only while no vertex is in flight.
    // ------------------------------------------------------------------
    logic signed [TW-1:0]          cos_reg, sin_reg;
    logic signed [SCALE_WIDTH-1:0] scale_a_reg, scale_b_reg, scale_h_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg     <= {1'b0, {TRIG_FRAC_BITS{1'b1}}};
            sin_reg     <= '0;
            scale_a_reg <= SCALE_ONE;
            scale_b_reg <= SCALE_ONE;
            scale_h_reg <= SCALE_ONE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROT_COSINE:   cos_reg     <= cfg_data[TW-1:0];
                REG_ROT_SINE:     sin_reg     <= cfg_data[TW-1:0];
                REG_SCALE_DIAG_A: scale_a_reg <= cfg_data[SCALE_WIDTH-1:0];
                REG_SCALE_DIAG_B: scale_b_reg <= cfg_data[SCALE_WIDTH-1:0];
                REG_SCALE_HEIGHT: scale_h_reg <= cfg_data[SCALE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   first_pending_reg;
    logic   m_valid_reg;
    logic   last_reg;
    logic [DIST_WIDTH-1:0] bit_reg;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL;
                    step_next  = STEP_SIN_Z;
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                step_next = step_t'(step_reg + 4'd1);
                case (step_reg)
                    STEP_SIN_X: state_next = ST_DIAG;
                    STEP_H_Y:   state_next = ST_COMB;
                    STEP_SQ_Z: begin
                        state_next = ST_UPDATE;
                        step_next  = STEP_SIN_Z;
                    end
                    default:    state_next = ST_MUL;
                endcase
            end
            ST_DIAG:   state_next = ST_MUL;
            ST_COMB:   state_next = ST_MUL;
            ST_UPDATE: state_next = last_reg ? ST_SQRT : ST_DONE;
            ST_SQRT: begin
                // The bit walks down even positions and ends at one.
                if (bit_reg[0]) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = aresetn && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            step_reg          <= STEP_SIN_Z;
            first_pending_reg <= 1'b1;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == ST_UPDATE) begin
                first_pending_reg <= last_reg;
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operands are taken as magnitudes, the sign is
    // carried beside the registered product.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] nx_reg, nz_reg, d_reg, s_reg, tx_reg, ty_reg;
    logic signed [CW-1:0] v_reg   [3];
    logic signed [CW-1:0] min_reg [3];
    logic signed [CW-1:0] max_reg [3];
    logic signed [SW-1:0] acc_reg;
    logic [DIST_WIDTH-1:0] dist_reg, md_reg, md_next, rem_reg;
    logic [MAGW-1:0]       res_reg;
    logic [PW-1:0]         prod_reg, prod_next;
    logic                  neg_reg, neg_next;
    logic [M_DW-1:0]       m_data_reg;
    logic                  m_last_reg;

    logic signed [OPW:0] opa, opb;

    always_comb begin
        case (step_reg)
            STEP_SIN_Z: begin opa = (OPW+1)'(sin_reg);     opb = (OPW+1)'(z_reg);    end
            STEP_COS_X: begin opa = (OPW+1)'(cos_reg);     opb = (OPW+1)'(x_reg);    end
            STEP_COS_Z: begin opa = (OPW+1)'(cos_reg);     opb = (OPW+1)'(z_reg);    end
            STEP_SIN_X: begin opa = (OPW+1)'(sin_reg);     opb = (OPW+1)'(x_reg);    end
            STEP_A_D:   begin opa = (OPW+1)'(scale_a_reg); opb = (OPW+1)'(d_reg);    end
            STEP_B_S:   begin opa = (OPW+1)'(scale_b_reg); opb = (OPW+1)'(s_reg);    end
            STEP_H_Y:   begin opa = (OPW+1)'(scale_h_reg); opb = (OPW+1)'(y_reg);    end
            STEP_SQ_X:  begin opa = (OPW+1)'(v_reg[0]);    opb = (OPW+1)'(v_reg[0]); end
            STEP_SQ_Y:  begin opa = (OPW+1)'(v_reg[1]);    opb = (OPW+1)'(v_reg[1]); end
            STEP_SQ_Z:  begin opa = (OPW+1)'(v_reg[2]);    opb = (OPW+1)'(v_reg[2]); end
            default:    begin opa = '0;                    opb = '0;                 end
        endcase
        neg_next  = opa[OPW] ^ opb[OPW];
        prod_next = PW'(mag_of(opa)) * PW'(mag_of(opb));
    end

    // Shift toward zero, then clamp the magnitude to what the step allows:
    // rotation terms keep one extra bit, scale terms the coordinate range,
    // squares the distance range.
    logic [PW-1:0]        shifted;
    logic [MAGW-1:0]      lim, mag_c;
    logic signed [SW-1:0] term;
    logic [DIST_WIDTH:0]  dist_sum;

    always_comb begin
        case (step_reg)
            STEP_SIN_Z, STEP_COS_X, STEP_COS_Z, STEP_SIN_X: begin
                shifted = prod_reg >> TRIG_FRAC_BITS;
                lim     = (MAGW'(1) << CW) - MAGW'(!neg_reg);
            end
            STEP_A_D, STEP_B_S: begin
                shifted = prod_reg >> (COORD_FRAC + 1);
                lim     = (MAGW'(1) << (CW - 1)) - MAGW'(!neg_reg);
            end
            STEP_H_Y: begin
                shifted = prod_reg >> COORD_FRAC;
                lim     = (MAGW'(1) << (CW - 1)) - MAGW'(!neg_reg);
            end
            default: begin
                shifted = prod_reg;
                lim     = DIST_MAX;
            end
        endcase
        mag_c    = (shifted > PW'(lim)) ? lim : shifted[MAGW-1:0];
        term     = neg_reg ? -$signed({1'b0, mag_c[CW:0]}) : $signed({1'b0, mag_c[CW:0]});
        dist_sum = {1'b0, dist_reg} + {1'b0, mag_c[DIST_WIDTH-1:0]};
    end

    // Running sphere radius squared after this vertex.
    always_comb begin
        if (first_pending_reg || dist_reg > md_reg) begin
            md_next = dist_reg;
        end else begin
            md_next = md_reg;
        end
    end

    // Square root trial subtraction.
    logic [MAGW-1:0] trial;
    assign trial = res_reg + MAGW'(bit_reg);

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                x_reg    <= s_tdata[CW-1:0];
                y_reg    <= s_tdata[2*CW-1:CW];
                z_reg    <= s_tdata[3*CW-1:2*CW];
                last_reg <= s_tlast;
            end
            ST_MUL: begin
                prod_reg <= prod_next;
                neg_reg  <= neg_next;
            end
            ST_ACC: begin
                case (step_reg)
                    STEP_SIN_Z, STEP_COS_Z: acc_reg <= term;
                    STEP_COS_X: nx_reg <= sat_cw(acc_reg + term);
                    STEP_SIN_X: nz_reg <= sat_cw(acc_reg - term);
                    STEP_A_D:   tx_reg <= term[CW-1:0];
                    STEP_B_S:   ty_reg <= term[CW-1:0];
                    STEP_H_Y:   v_reg[1] <= term[CW-1:0];
                    STEP_SQ_X:  dist_reg <= mag_c[DIST_WIDTH-1:0];
                    default: begin
                        // Saturating add of the remaining squares.
                        dist_reg <= dist_sum[DIST_WIDTH] ? DIST_MAX[DIST_WIDTH-1:0]
                                                         : dist_sum[DIST_WIDTH-1:0];
                    end
                endcase
            end
            ST_DIAG: begin
                d_reg <= sat_cw(SW'(nz_reg) - SW'(nx_reg));
                s_reg <= sat_cw(SW'(nx_reg) + SW'(nz_reg));
            end
            ST_COMB: begin
                v_reg[0] <= sat_cw(SW'(ty_reg) - SW'(tx_reg));
                v_reg[2] <= sat_cw(SW'(tx_reg) + SW'(ty_reg));
            end
            ST_UPDATE: begin
                for (int i = 0; i < 3; i++) begin
                    if (first_pending_reg || v_reg[i] < min_reg[i]) begin
                        min_reg[i] <= v_reg[i];
                    end
                    if (first_pending_reg || v_reg[i] > max_reg[i]) begin
                        max_reg[i] <= v_reg[i];
                    end
                end
                md_reg  <= md_next;
                rem_reg <= md_next;
                res_reg <= '0;
                bit_reg <= {1'b1, {(DIST_WIDTH-1){1'b0}}};
            end
            ST_SQRT: begin
                if ({1'b0, rem_reg} >= trial) begin
                    rem_reg <= rem_reg - trial[DIST_WIDTH-1:0];
                    res_reg <= (res_reg >> 1) + MAGW'(bit_reg);
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= M_DW'({
                        (last_reg ? res_reg[RADIUS_WIDTH-1:0] : {RADIUS_WIDTH{1'b0}}),
                        md_reg,
                        max_reg[2], max_reg[1], max_reg[0],
                        min_reg[2], min_reg[1], min_reg[0],
                        v_reg[2], v_reg[1], v_reg[0]});
                    m_last_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    logic [RADIUS_WIDTH-1:0] chk_radius;
    logic [DIST_WIDTH-1:0]   chk_rsq;
    assign chk_radius = m_data_reg[RAD_LSB +: RADIUS_WIDTH];
    assign chk_rsq    = m_data_reg[RSQ_LSB +: DIST_WIDTH];

    // A vertex is never taken while the previous one is being worked on.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // The box stays ordered whenever a result is about to be published.
    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |->
            min_reg[0] <= max_reg[0] && min_reg[1] <= max_reg[1] &&
            min_reg[2] <= max_reg[2])
        else $error("bounding box min exceeds max");

    // Only the closing word of a mesh carries a radius.
    a_radius_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> chk_radius == '0)
        else $error("radius set on a word that is not last");

    // The radius is never larger than the square root of its square.
    a_radius_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |->
            64'(chk_radius) * 64'(chk_radius) <= 64'(chk_rsq))
        else $error("radius exceeds square root of radius squared");

endmodule
